// ===== design/ppbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppbf_pkg: shared types and constants of the phase-pointer byte FIFO
// Widths, register index codes, item kind codes and the pointer type.
// ----------------------------------------------------------------------------
package ppbf_pkg;

    localparam int MAX_BYTES   = 1024;
    localparam int LANES       = 4;
    localparam int STORE_WORDS = MAX_BYTES / LANES;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int LANE_W      = $clog2(LANES);
    localparam int OFF_W       = $clog2(MAX_BYTES);
    localparam int LVL_W       = OFF_W + 1;
    localparam int BYTE_W      = 8;
    localparam int RESERVE_W   = 7;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    typedef logic [OFF_W-1:0]       offset_t;
    typedef logic [LVL_W-1:0]       level_t;
    typedef logic [BYTE_W-1:0]      byte_t;
    typedef logic [RESERVE_W-1:0]   reserve_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [LANE_W-1:0]      lane_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIFO_SIZE = 1'b0,
        REG_RESERVE   = 1'b1
    } cfg_reg_t;

    // Item kind codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Size limits after rounding
    localparam level_t SIZE_MIN   = LVL_W'(LANES);
    localparam level_t SIZE_MAX   = LVL_W'(MAX_BYTES);
    localparam level_t SIZE_RESET = LVL_W'(MAX_BYTES);
    localparam reserve_t RESERVE_RESET = RESERVE_W'(4);

    // Byte pointer: offset plus wrap phase
    typedef struct packed {
        offset_t offset;
        logic    phase;
    } ptr_t;

endpackage : ppbf_pkg
`default_nettype wire

// ===== design/ppbf_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppbf_cmd_if: command channel of the byte FIFO
// Carries one push or pop item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppbf_cmd_if;
    import ppbf_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    byte_t data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);

endinterface : ppbf_cmd_if
`default_nettype wire

// ===== design/ppbf_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppbf_rsp_if: result channel of the byte FIFO
// Carries one result item per command with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppbf_rsp_if;
    import ppbf_pkg::*;

    logic    valid;
    logic    ready;
    logic    accepted;
    byte_t   read_byte;
    level_t  occupancy;
    offset_t write_offset_out;
    logic    write_phase_out;
    offset_t read_offset_out;
    logic    read_phase_out;

    modport source (
        output valid, output accepted, output read_byte, output occupancy,
        output write_offset_out, output write_phase_out,
        output read_offset_out, output read_phase_out,
        input  ready
    );
    modport sink (
        input  valid, input accepted, input read_byte, input occupancy,
        input  write_offset_out, input write_phase_out,
        input  read_offset_out, input read_phase_out,
        output ready
    );

endinterface : ppbf_rsp_if
`default_nettype wire

// ===== design/ppbf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppbf_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : ppbf_ram
`default_nettype wire

// ===== design/phase_pointer_byte_fifo_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phase_pointer_byte_fifo_core: byte FIFO with phase-bit pointers
// Byte FIFO held in four byte-lane memories, one push or pop per item.
// ----------------------------------------------------------------------------
// The block takes one command item per clock cycle unless a stalled result
// has backed up into the read stage, and gives exactly one result item for
// each. An accepted item passes the read stage, the registered read of the
// lane memories that a pop needs before its byte can be shown, and then the
// output register. Pointers update at acceptance, so back-to-back pushes and
// pops see each other at once. A stalled result holds in the output register
// while one more item sits in the read stage. Writing fifo_size empties the
// FIFO (pointers and phases cleared); the stored bytes stay. Sizes are rounded
// down to a multiple of four and kept within 4 to 1024 bytes.
module phase_pointer_byte_fifo_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ppbf_cmd_if.sink                   cmd,
    ppbf_rsp_if.source                 rsp,
    input  wire logic                  cfg_write_en,
    input  wire ppbf_pkg::cfg_index_t  cfg_index,
    input  wire ppbf_pkg::cfg_data_t   cfg_data
);
    import ppbf_pkg::*;

    // Occupancy from a pair of pointers
    function automatic level_t fill_level(ptr_t w, ptr_t r, level_t size);
        level_t lvl;
        if (w.phase == r.phase)
        begin
            lvl = LVL_W'(w.offset) - LVL_W'(r.offset);
        end
        else
        begin
            lvl = size - LVL_W'(r.offset) + LVL_W'(w.offset);
        end
        return lvl;
    endfunction

    // Step a pointer, wrapping at the size and toggling the phase
    function automatic ptr_t advance(ptr_t p, level_t size);
        level_t n;
        ptr_t   q;
        n = LVL_W'(p.offset) + LVL_W'(1);
        if (n >= size)
        begin
            q.offset = '0;
            q.phase  = ~p.phase;
        end
        else
        begin
            q.offset = n[OFF_W-1:0];
            q.phase  = p.phase;
        end
        return q;
    endfunction

    // Round and clamp a size write
    function automatic level_t clamp_size(cfg_data_t v);
        level_t s;
        s = {v[CFG_DATA_W-1:LANE_W], {LANE_W{1'b0}}};
        if (s > SIZE_MAX)
        begin
            s = SIZE_MAX;
        end
        if (s < SIZE_MIN)
        begin
            s = SIZE_MIN;
        end
        return s;
    endfunction

    level_t   size_reg;
    reserve_t reserve_reg;
    ptr_t     wptr_reg, wptr_next;
    ptr_t     rptr_reg, rptr_next;

    level_t   level_now;
    level_t   level_next;
    level_t   limit;
    logic     cmd_fire;
    logic     push_ok;
    logic     pop_ok;

    logic     s1_valid_reg, s1_valid_next;
    logic     s1_move;
    logic     s1_acc_reg;
    logic     s1_pop_reg;
    lane_t    s1_lane_reg;
    level_t   s1_level_reg;
    ptr_t     s1_wptr_reg;
    ptr_t     s1_rptr_reg;

    logic     out_valid_reg, out_valid_next;
    logic     out_acc_reg;
    byte_t    out_byte_reg;
    level_t   out_level_reg;
    ptr_t     out_wptr_reg;
    ptr_t     out_rptr_reg;

    byte_t    lane_rdata [LANES];
    byte_t    sel_byte;

    // Decide the item against the current pointers
    assign level_now = fill_level(wptr_reg, rptr_reg, size_reg);
    assign limit     = (LVL_W'(reserve_reg) < size_reg) ?
                       size_reg - LVL_W'(reserve_reg) : '0;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign push_ok   = (cmd.kind == KIND_PUSH) && (level_now < limit);
    assign pop_ok    = (cmd.kind == KIND_POP) && (level_now != '0);

    assign wptr_next  = (cmd_fire && push_ok) ? advance(wptr_reg, size_reg) : wptr_reg;
    assign rptr_next  = (cmd_fire && pop_ok) ? advance(rptr_reg, size_reg) : rptr_reg;
    assign level_next = fill_level(wptr_next, rptr_next, size_reg);

    // Hold configuration; a size write empties the FIFO
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= SIZE_RESET;
            reserve_reg <= RESERVE_RESET;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FIFO_SIZE:
                begin
                    size_reg <= clamp_size(cfg_data);
                    wptr_reg <= '0;
                    rptr_reg <= '0;
                end
                REG_RESERVE:
                begin
                    reserve_reg <= cfg_data[RESERVE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    // Lane memories: write one lane on push, read all lanes on pop
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        ppbf_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (STORE_WORDS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (cmd_fire && push_ok && (wptr_reg.offset[LANE_W-1:0] == LANE_W'(i))),
            .wr_addr (wptr_reg.offset[OFF_W-1:LANE_W]),
            .wr_data (cmd.data_byte),
            .rd_en   (cmd_fire && pop_ok),
            .rd_addr (rptr_reg.offset[OFF_W-1:LANE_W]),
            .rd_data (lane_rdata[i])
        );
    end

    // Handshake: advance the read stage into the output register
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_move;

    assign s1_valid_next  = cmd_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pick the popped lane, drop it on push or refused pop
    assign sel_byte = s1_pop_reg ? lane_rdata[s1_lane_reg] : '0;

    // Capture item results
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_acc_reg   <= push_ok || pop_ok;
            s1_pop_reg   <= pop_ok;
            s1_lane_reg  <= rptr_reg.offset[LANE_W-1:0];
            s1_level_reg <= level_next;
            s1_wptr_reg  <= wptr_next;
            s1_rptr_reg  <= rptr_next;
        end
        if (s1_move)
        begin
            out_acc_reg   <= s1_acc_reg;
            out_byte_reg  <= sel_byte;
            out_level_reg <= s1_level_reg;
            out_wptr_reg  <= s1_wptr_reg;
            out_rptr_reg  <= s1_rptr_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.accepted         = out_acc_reg;
    assign rsp.read_byte        = out_byte_reg;
    assign rsp.occupancy        = out_level_reg;
    assign rsp.write_offset_out = out_wptr_reg.offset;
    assign rsp.write_phase_out  = out_wptr_reg.phase;
    assign rsp.read_offset_out  = out_rptr_reg.offset;
    assign rsp.read_phase_out   = out_rptr_reg.phase;

endmodule : phase_pointer_byte_fifo_core
`default_nettype wire
